[hdl/wmmd_pkg.sv]
// Shared constants, register indexes and controller/datapath interface types
// for the waveform min/max decimator. No dependencies.
package wmmd_pkg;

  localparam int unsigned NumColumns = 64;
  localparam int unsigned ColW       = $clog2(NumColumns);  // column index width
  localparam int unsigned ColCntW    = ColW + 1;            // counter that reaches NumColumns
  localparam int unsigned CountW     = 24;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned HighW      = 15;
  localparam int unsigned MulW       = ColCntW + CountW;
  localparam int unsigned InDataW    = 2 * SampleW;
  localparam int unsigned OutFieldW  = ColW + SampleW + HighW;
  localparam int unsigned OutDataW   = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned OutPadW    = OutDataW - OutFieldW;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegSampleCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegStereoMode  = CfgIdxW'(1);

  // controller -> datapath
  typedef struct packed {
    logic load_v;     // latch the incoming sample
    logic cfg_we;     // configuration write accepted
    logic take;       // fold latched sample into running min/max
    logic close;      // park the column result, step column, clear min/max
    logic mul_start;  // compute start of current column
    logic mul_end;    // compute end of current column, take if it already opened
    logic emit;       // load parked result into output register
    logic last;       // tlast of emitted item
    logic advance;    // step sample position
  } wmmd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic active;     // position inside clip and a column still open
    logic col_open;   // a column still open
    logic closes;     // current sample closes the current column
    logic out_busy;   // output register holds an item not yet taken
  } wmmd_sts_t;

endpackage

[hdl/wmmd_datapath.sv]
// Datapath of the min/max decimator: config registers, running min/max,
// column bookkeeping with a shared 7x24 multiplier, output register. Uses wmmd_pkg.
module wmmd_datapath import wmmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wmmd_cmd_t             cmd_i,
  output wmmd_sts_t             sts_o,
  input  logic [InDataW-1:0]    in_data_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CountW-1:0]     cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [ColW-1:0]       out_col_o,
  output logic signed [SampleW-1:0] out_low_o,
  output logic [HighW-1:0]      out_high_o,
  output logic                  out_last_o
);

  logic [CountW-1:0]         count_q;
  logic                      stereo_q;
  logic [CountW-1:0]         pos_q;
  logic [ColCntW-1:0]        col_q;
  logic signed [SampleW-1:0] low_q;
  logic [HighW-1:0]          high_q;
  logic [CountW-1:0]         end_q;
  logic [CountW-1:0]         start_q;
  logic signed [SampleW-1:0] v_q;
  logic [ColW-1:0]           pend_col_q;
  logic signed [SampleW-1:0] pend_low_q;
  logic [HighW-1:0]          pend_high_q;
  logic                      out_valid_q;

  logic signed [SampleW-1:0] left_s, right_s, v_d;
  logic [SampleW:0]          sum17;
  logic [ColCntW-1:0]        mul_op;
  logic [MulW-1:0]           prod;
  logic [CountW-1:0]         prod_sh;
  logic [CountW-1:0]         start_inc;
  logic [CountW:0]           pos_inc;
  logic [CountW-1:0]         first_end;
  logic                      take_en;
  logic signed [SampleW-1:0] low_take;
  logic [HighW-1:0]          high_take;

  assign left_s  = in_data_i[SampleW-1:0];
  assign right_s = in_data_i[InDataW-1:SampleW];
  assign sum17   = {left_s[SampleW-1], left_s} + {right_s[SampleW-1], right_s};
  // floor average: drop the low bit of the 17-bit sum
  assign v_d     = stereo_q ? sum17[SampleW:1] : left_s;

  assign mul_op    = cmd_i.mul_end ? col_q + ColCntW'(1) : col_q;
  assign prod      = MulW'(mul_op) * MulW'(count_q);
  assign prod_sh   = prod[ColW +: CountW];
  assign start_inc = start_q + CountW'(1);
  assign pos_inc   = {1'b0, pos_q} + (CountW+1)'(1);
  assign first_end = (cfg_data_i[CountW-1:ColW] == '0) ? CountW'(1)
                                                        : CountW'(cfg_data_i[CountW-1:ColW]);

  assign take_en   = cmd_i.take || (cmd_i.mul_end && (start_q <= pos_q));
  assign low_take  = (v_q < low_q) ? v_q : low_q;
  assign high_take = (!v_q[SampleW-1] && (v_q[HighW-1:0] > high_q)) ? v_q[HighW-1:0] : high_q;

  assign sts_o.col_open = (col_q < ColCntW'(NumColumns));
  assign sts_o.active   = sts_o.col_open && (pos_q < count_q);
  assign sts_o.closes   = sts_o.col_open && (pos_inc >= {1'b0, end_q});
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CountW'(1);
      stereo_q    <= 1'b0;
      pos_q       <= '0;
      col_q       <= '0;
      low_q       <= '0;
      high_q      <= '0;
      end_q       <= CountW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        if (cfg_index_i == RegSampleCount) begin
          count_q <= cfg_data_i;
          pos_q   <= '0;
          col_q   <= '0;
          low_q   <= '0;
          high_q  <= '0;
          end_q   <= first_end;
        end else if (cfg_index_i == RegStereoMode) begin
          stereo_q <= cfg_data_i[0];
        end
      end
      if (cmd_i.close) begin
        col_q  <= col_q + ColCntW'(1);
        low_q  <= '0;
        high_q <= '0;
      end else if (take_en) begin
        low_q  <= low_take;
        high_q <= high_take;
      end
      if (cmd_i.mul_end) begin
        end_q <= (prod_sh > start_inc) ? prod_sh : start_inc;
      end
      if (cmd_i.advance) begin
        pos_q <= pos_q + CountW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_v) begin
      v_q <= v_d;
    end
    if (cmd_i.mul_start) begin
      start_q <= prod_sh;
    end
    if (cmd_i.close) begin
      pend_col_q  <= col_q[ColW-1:0];
      pend_low_q  <= low_q;
      pend_high_q <= high_q;
    end
    if (cmd_i.emit) begin
      out_col_o  <= pend_col_q;
      out_low_o  <= pend_low_q;
      out_high_o <= pend_high_q;
      out_last_o <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/wmmd_ctrl.sv]
// Controller of the min/max decimator: sequences take, column close,
// next-column bounds and result emission. Uses wmmd_pkg.
module wmmd_ctrl import wmmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  wmmd_sts_t sts_i,
  output wmmd_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_CHECK,
    S_CLOSE,
    S_MUL_START,
    S_MUL_END,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        // a pending register write goes ahead of an input item
        in_ready_o   = !cfg_valid_i;
        cfg_ready_o  = 1'b1;
        cmd_o.cfg_we = cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          cmd_o.load_v = 1'b1;
          state_d      = S_TAKE;
        end
      end
      S_TAKE: begin
        if (sts_i.active) begin
          cmd_o.take = 1'b1;
          state_d    = S_CHECK;
        end else begin
          state_d = S_IDLE;  // past the clip: item dropped
        end
      end
      S_CHECK: begin
        if (sts_i.closes) begin
          state_d = S_CLOSE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_CLOSE: begin
        cmd_o.close = 1'b1;
        state_d     = S_MUL_START;
      end
      S_MUL_START: begin
        if (sts_i.col_open) begin
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL_END;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_MUL_END: begin
        cmd_o.mul_end = 1'b1;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = !sts_i.closes;
          if (sts_i.closes) begin
            state_d = S_CLOSE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/waveform_min_max_decimator_unit.sv]
// Min/max waveform decimator: reduces a clip of sample_count samples to 64 display columns,
// one min/max pair per column. An item past the clip is dropped; one that closes no column
// is folded in and steps the position. For each column it closes, the shared multiplier
// works out the next column's start and end in two steps, skipped after the final column 63,
// and the result waits while the output register holds an item m_axis_tready_i has not taken.
// A result item may wait in the output register while the next column is being computed.
// A pending register write is taken ahead of an input item.
// Top level: wmmd_ctrl + wmmd_datapath, uses wmmd_pkg.
module waveform_min_max_decimator_unit import wmmd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InDataW-1:0]   s_axis_tdata_i,   // left_sample[15:0], right_sample[31:16]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutDataW-1:0]  m_axis_tdata_o,   // column_index[5:0], peak_low[21:6],
                                                 // peak_high[36:22], zero[39:37]
  output logic                 m_axis_tlast_o,   // last_of_run
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CountW-1:0]    cfg_data_i
);

  wmmd_cmd_t                 cmd;
  wmmd_sts_t                 sts;
  logic [ColW-1:0]           out_col;
  logic signed [SampleW-1:0] out_low;
  logic [HighW-1:0]          out_high;

  wmmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wmmd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_col_o   (out_col),
    .out_low_o   (out_low),
    .out_high_o  (out_high),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{OutPadW{1'b0}}, out_high, out_low, out_col};

endmodule

[hdl/wmmd_checker.sv]
// Port-level checks for waveform_min_max_decimator_unit, attached by bind.
// Uses wmmd_pkg.
module wmmd_checker import wmmd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o,
  input logic                cfg_ready_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted back to back");

  // input is taken only while idle, where config is taken too
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> cfg_ready_o)
    else $error("input ready outside idle");

  // low peak never above zero, pad bits zero
  a_peak_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[ColW+SampleW-1] || (m_axis_tdata_o[ColW +: SampleW] == '0)) &&
      (m_axis_tdata_o[OutDataW-1:OutFieldW] == '0))
    else $error("bad peak_low or padding");

endmodule

bind waveform_min_max_decimator_unit wmmd_checker u_wmmd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .cfg_ready_o     (cfg_ready_o)
);

[tb/waveform_min_max_decimator_unit_test.sv]
// Self-checking testbench for the min/max waveform decimator: drives audio samples and
// register writes, predicts every column result and checks it. Depends on wmmd_pkg and
// waveform_min_max_decimator_unit.
`timescale 1ns / 1ps

module waveform_min_max_decimator_unit_test;
  import wmmd_pkg::*;

  // indexes that decode to no register
  localparam logic [CfgIdxW-1:0] RegSpare2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpare3 = CfgIdxW'(3);

  typedef struct {
    logic [5:0]  column;
    logic [15:0] low;
    logic [14:0] high;
    logic        last;
  } peak_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;  // left_sample[15:0], right_sample[31:16]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;       // column_index[5:0], peak_low[21:6],
                                             // peak_high[36:22], zero[39:37]
  logic                m_axis_tlast_o;       // last_of_run
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CountW-1:0]   cfg_data_i = '0;

  waveform_min_max_decimator_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [CountW-1:0] clip_len;
  logic              stereo_on;
  int unsigned       sample_pos;
  int unsigned       open_col;
  int                low_run;
  int                high_run;
  int unsigned       col_stop_pos;

  peak_t pending_peaks[$];

  int err_count      = 0;
  int peaks_checked  = 0;
  int taken_count    = 0;
  int clips_run      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  function automatic int unsigned col_start(int unsigned k);
    return int'((longint'(k) * longint'(clip_len)) / NumColumns);
  endfunction

  function automatic int unsigned col_stop(int unsigned k);
    int unsigned s;
    int unsigned e;
    s = col_start(k) + 1;
    e = int'((longint'(k + 1) * longint'(clip_len)) / NumColumns);
    return (e > s) ? e : s;
  endfunction

  function automatic void restart_clip();
    sample_pos   = 0;
    open_col     = 0;
    low_run      = 0;
    high_run     = 0;
    col_stop_pos = col_stop(0);
  endfunction

  function automatic void fold_into_peaks(int v);
    if (v < low_run) low_run = v;
    if (v > high_run) high_run = v;
  endfunction

  // Returns 1 when the sample falls inside the clip; queues the columns it closes.
  function automatic bit predict_peaks(logic [15:0] left, logic [15:0] right);
    int    v;
    bit    have_prev;
    peak_t prev;
    peak_t p;
    v = int'($signed(left));
    if (stereo_on) v = (int'($signed(left)) + int'($signed(right))) >>> 1;
    if (sample_pos >= clip_len || open_col >= NumColumns) return 1'b0;
    fold_into_peaks(v);
    have_prev = 1'b0;
    while (open_col < NumColumns && sample_pos + 1 >= col_stop_pos) begin
      p.column = open_col[5:0];
      p.low    = low_run[15:0];
      p.high   = high_run[14:0];
      p.last   = 1'b0;
      if (have_prev) pending_peaks.push_back(prev);
      prev      = p;
      have_prev = 1'b1;
      open_col++;
      low_run  = 0;
      high_run = 0;
      if (open_col < NumColumns) begin
        col_stop_pos = col_stop(open_col);
        // a column opening at this position takes the same sample
        if (col_start(open_col) <= sample_pos) fold_into_peaks(v);
      end
    end
    sample_pos = (sample_pos + 1) & 32'hFF_FFFF;
    if (have_prev) begin
      prev.last = 1'b1;
      pending_peaks.push_back(prev);
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    peak_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_peaks.size() == 0) begin
        $error("column result with none expected: column_index %0d", m_axis_tdata_o[5:0]);
        err_count++;
      end else begin
        e = pending_peaks.pop_front();
        peaks_checked++;
        if (m_axis_tdata_o[5:0] !== e.column) begin
          $error("column_index: expected %0d, got %0d", e.column, m_axis_tdata_o[5:0]);
          err_count++;
        end
        if (m_axis_tdata_o[21:6] !== e.low) begin
          $error("peak_low: expected %0d, got %0d", $signed(e.low),
                 $signed(m_axis_tdata_o[21:6]));
          err_count++;
        end
        if (m_axis_tdata_o[36:22] !== e.high) begin
          $error("peak_high: expected %0d, got %0d", e.high, m_axis_tdata_o[36:22]);
          err_count++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last_of_run: expected %0b, got %0b", e.last, m_axis_tlast_o);
          err_count++;
        end
      end
    end
  end

  task automatic send_sample(input logic [15:0] left, input logic [15:0] right);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {right, left};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_peaks(left, right)) taken_count++;
  endtask

  // Hold off the sender until all columns are out, then let a sample that
  // closes nothing finish as well.
  task automatic drain_peaks();
    s_axis_tvalid_i <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] val);
    drain_peaks();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegSampleCount: begin
        clip_len = val;
        restart_clip();
        clips_run++;
      end
      RegStereoMode: stereo_on = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(600)) - 16'd300;
      1: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Reset clip length is one: a single sample closes every column.
  task automatic test_reset_defaults();
    send_sample(16'h7FFF, 16'h8000);
  endtask

  task automatic test_mono_extremes();
    write_reg(RegSampleCount, 24'd64);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0001, 16'h5555);
  endtask

  // Continues the clip above; mode switches take effect without a restart.
  task automatic test_stereo_average();
    write_reg(RegStereoMode, 24'hFF_FFFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'hFFFD, 16'hFFFC);
    write_reg(RegStereoMode, 24'hFF_FFFE);
    send_sample(16'h8000, 16'h7FFF);
  endtask

  // Fewer samples than columns; the last one is past the clip.
  task automatic test_short_clip();
    write_reg(RegSampleCount, 24'd5);
    send_sample(16'h1234, 16'h0);
    send_sample(16'hC000, 16'h0);
    send_sample(16'h4000, 16'h0);
    send_sample(16'hFF00, 16'h0);
    send_sample(16'h0100, 16'h0);
    send_sample(16'h7FFF, 16'h0);
  endtask

  task automatic test_zero_count();
    write_reg(RegSampleCount, 24'd0);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
  endtask

  task automatic test_unknown_index();
    write_reg(RegSampleCount, 24'd4);
    send_sample(16'h2000, 16'h0);
    send_sample(16'hE000, 16'h0);
    write_reg(RegSpare2, 24'($urandom));
    write_reg(RegSpare3, 24'($urandom));
    send_sample(16'h0FFF, 16'h0);
    send_sample(16'hF001, 16'h0);
  endtask

  task automatic test_max_count();
    write_reg(RegSampleCount, 24'hFF_FFFF);
    send_sample(16'h8000, 16'h0);
    send_sample(16'h7FFF, 16'h0);
    send_sample(16'h0000, 16'h0);
  endtask

  task automatic test_random_clips(input int send_pct, input int recv_pct, input int target);
    int          n_sent;
    int          r;
    int unsigned len;
    int unsigned n_send;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    n_sent         = 0;
    while (n_sent < target) begin
      r = $urandom_range(99);
      if (r < 30)      len = $urandom_range(63, 1);
      else if (r < 85) len = $urandom_range(160, 64);
      else if (r < 95) len = $urandom_range(300, 161);
      else             len = $urandom_range(24'hFF_FFFF, 1000);
      if ($urandom_range(3) == 0) write_reg(RegStereoMode, 24'($urandom));
      write_reg(RegSampleCount, len[CountW-1:0]);
      if (len >= 1000)
        n_send = $urandom_range(12, 4);
      else if ($urandom_range(9) == 0)
        n_send = $urandom_range(len, 1);        // clip cut short by the next write
      else
        n_send = len + $urandom_range(3);       // a few samples past the clip
      for (int unsigned i = 0; i < n_send && n_sent < target; i++) begin
        send_sample(pick_sample(), pick_sample());
        n_sent++;
      end
    end
  endtask

  initial begin
    clip_len  = 24'd1;
    stereo_on = 1'b0;
    restart_clip();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 20;
    recv_stall_pct = 87;
    test_reset_defaults();
    test_mono_extremes();
    test_stereo_average();
    test_short_clip();
    test_zero_count();
    test_unknown_index();
    test_max_count();

    test_random_clips(20, 87, 134);
    test_random_clips(87, 20, 134);
    test_random_clips(0, 0, 134);

    drain_peaks();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d column results from %0d in-clip samples over %0d clips",
             peaks_checked, taken_count, clips_run);
    $display("Mono and stereo, short and long clips, ignored samples, spare indexes, stalls");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
hdl/wmmd_pkg.sv
hdl/wmmd_datapath.sv
hdl/wmmd_ctrl.sv
hdl/waveform_min_max_decimator_unit.sv
hdl/wmmd_checker.sv
tb/waveform_min_max_decimator_unit_test.sv
